>>> rtl/row_to_page_bitmap_transpose_assert.svh
// ---------------------------------------------------------------------------
// Assertion macros for the row-to-page bitmap transpose
// Immediate-antecedent and next-cycle implication checks, reset-qualified.
// ---------------------------------------------------------------------------
`ifndef ROW_TO_PAGE_BITMAP_TRANSPOSE_ASSERT_SVH
`define ROW_TO_PAGE_BITMAP_TRANSPOSE_ASSERT_SVH

// ante implies cons in the same cycle
`define RTPB_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// ante implies cons in the next cycle
`define RTPB_ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> rtl/rtpb_pkg.sv
// ---------------------------------------------------------------------------
// rtpb_pkg
// Shared constants and types of the row-to-page bitmap transpose.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package rtpb_pkg;

    // Default store geometry
    localparam int MAX_WIDTH_BYTES_DEF = 16;
    localparam int MAX_PAGES_DEF       = 8;

    // Band geometry: seven stored rows plus the live eighth row
    localparam int STORE_ROWS = 7;
    localparam int BAND_ROWS  = 8;
    localparam int BEATS      = 8;

    // Configuration port
    localparam int CFG_IDX_W  = 4;
    localparam int CFG_DATA_W = 8;
    localparam int WB_W       = 5;
    localparam int HP_W       = 4;

    localparam logic [CFG_IDX_W-1:0] REG_WIDTH_BYTES  = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] REG_HEIGHT_PAGES = CFG_IDX_W'(1);

    localparam logic [WB_W-1:0] WIDTH_RESET  = WB_W'(16);
    localparam logic [HP_W-1:0] HEIGHT_RESET = HP_W'(4);

    // Queue between front and back
    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = 1;
    localparam int QCNT_W      = 2;

    // One eighth-row byte with the seven stored bytes of its column group
    typedef struct packed {
        logic [7:0]                  pixel;
        logic [STORE_ROWS-1:0][7:0]  rows;
        logic                        frame_last;
    } t_band_word;

    typedef struct packed {
        logic       valid;
        t_band_word word;
    } t_word_req;

endpackage

`default_nettype wire

>>> rtl/rtpb_ifs.sv
// ---------------------------------------------------------------------------
// rtpb interfaces
// Valid/ready channels for pixel bytes, column bytes and register writes.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

interface rtpb_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] pixel_byte;

    modport source (output valid, output pixel_byte, input ready);
    modport sink   (input valid, input pixel_byte, output ready);
endinterface

interface rtpb_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] column_byte;
    logic       run_last;
    logic       frame_last;

    modport source (output valid, output column_byte, output run_last,
                    output frame_last, input ready);
    modport sink   (input valid, input column_byte, input run_last,
                    input frame_last, output ready);
endinterface

interface rtpb_cfg_if;
    logic                          valid;
    logic                          ready;
    logic [rtpb_pkg::CFG_IDX_W-1:0]  index;
    logic [rtpb_pkg::CFG_DATA_W-1:0] data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

>>> rtl/rtpb_front.sv
// ---------------------------------------------------------------------------
// rtpb_front
// Tracks row, column and page, stores rows 0..6 of each band and hands each
// eighth-row byte with its stored column bytes to the queue.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
`include "row_to_page_bitmap_transpose_assert.svh"

module rtpb_front #(
    parameter int MAX_WIDTH_BYTES = rtpb_pkg::MAX_WIDTH_BYTES_DEF,
    parameter int MAX_PAGES       = rtpb_pkg::MAX_PAGES_DEF
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    rtpb_cfg_if.sink            i_cfg,
    rtpb_in_if.sink             i_pix,
    output rtpb_pkg::t_word_req o_push,
    input  logic                i_push_ready
);
    import rtpb_pkg::*;

    localparam int CW = (MAX_WIDTH_BYTES > 1) ? $clog2(MAX_WIDTH_BYTES) : 1;
    localparam int PW = (MAX_PAGES > 1) ? $clog2(MAX_PAGES) : 1;
    localparam logic [2:0] LAST_ROW = 3'(BAND_ROWS - 1);

    logic [WB_W-1:0] r_width_raw;
    logic [HP_W-1:0] r_height_raw;
    logic [2:0]      r_row;
    logic [CW-1:0]   r_col;
    logic [PW-1:0]   r_page;
    logic            r_s1_valid;
    t_band_word      r_s1_word;
    logic [7:0]      r_bank [STORE_ROWS][MAX_WIDTH_BYTES];

    logic [CW-1:0] w_m1;
    logic [PW-1:0] h_m1;
    logic [CW-1:0] col_eff;
    logic          row7;
    logic          last_col;
    logic          last_page;
    logic          accept;
    logic          cfg_we;
    logic          push;

    // Clamp register values to 1..max, kept as max index
    always_comb begin
        if (r_width_raw == '0) begin
            w_m1 = '0;
        end else if (32'(r_width_raw) > MAX_WIDTH_BYTES) begin
            w_m1 = CW'(MAX_WIDTH_BYTES - 1);
        end else begin
            w_m1 = CW'(r_width_raw - 1'b1);
        end
        if (r_height_raw == '0) begin
            h_m1 = '0;
        end else if (32'(r_height_raw) > MAX_PAGES) begin
            h_m1 = PW'(MAX_PAGES - 1);
        end else begin
            h_m1 = PW'(r_height_raw - 1'b1);
        end
    end

    assign col_eff   = (r_col > w_m1) ? w_m1 : r_col;
    assign row7      = (r_row == LAST_ROW);
    assign last_col  = (col_eff == w_m1);
    assign last_page = (r_page >= h_m1);

    // Stored rows never stall; the eighth row waits for a free stage
    assign i_pix.ready = !row7 || !r_s1_valid || i_push_ready;
    assign i_cfg.ready = 1'b1;
    assign accept      = i_pix.valid && i_pix.ready;
    assign cfg_we      = i_cfg.valid && i_cfg.ready;
    assign push        = r_s1_valid && i_push_ready;

    assign o_push.valid = r_s1_valid;
    assign o_push.word  = r_s1_word;

    // Configuration registers and position counters
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_width_raw  <= WIDTH_RESET;
            r_height_raw <= HEIGHT_RESET;
            r_row        <= '0;
            r_col        <= '0;
            r_page       <= '0;
        end else if (cfg_we) begin
            if (i_cfg.index == REG_WIDTH_BYTES) begin
                r_width_raw <= i_cfg.data[WB_W-1:0];
                r_row       <= '0;
                r_col       <= '0;
                r_page      <= '0;
            end else if (i_cfg.index == REG_HEIGHT_PAGES) begin
                r_height_raw <= i_cfg.data[HP_W-1:0];
                r_row        <= '0;
                r_col        <= '0;
                r_page       <= '0;
            end
        end else if (accept) begin
            if (last_col) begin
                r_col <= '0;
                if (row7) begin
                    r_row  <= '0;
                    r_page <= last_page ? '0 : r_page + 1'b1;
                end else begin
                    r_row <= r_row + 1'b1;
                end
            end else begin
                r_col <= col_eff + 1'b1;
            end
        end
    end

    // Band store: write stored rows, read all seven at the column on row 7
    always_ff @(posedge i_clk) begin
        if (accept && !row7) begin
            r_bank[r_row][col_eff] <= i_pix.pixel_byte;
        end
        if (accept && row7) begin
            for (int r = 0; r < STORE_ROWS; r++) begin
                r_s1_word.rows[r] <= r_bank[r][col_eff];
            end
            r_s1_word.pixel      <= i_pix.pixel_byte;
            r_s1_word.frame_last <= last_col && last_page;
        end
    end

    // Hand-off stage valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (accept && row7) begin
            r_s1_valid <= 1'b1;
        end else if (push) begin
            r_s1_valid <= 1'b0;
        end
    end

    `RTPB_ASSERT_IMP(a_col_range, i_clk, i_rst_n, 1'b1, r_col <= w_m1, "column past width")
    `RTPB_ASSERT_IMP(a_page_range, i_clk, i_rst_n, 1'b1, r_page <= h_m1, "page past height")
    `RTPB_ASSERT_NXT(a_stage_hold, i_clk, i_rst_n, r_s1_valid && !i_push_ready,
        r_s1_valid && $stable(r_s1_word), "stalled hand-off word changed")

endmodule

`default_nettype wire

>>> rtl/rtpb_queue.sv
// ---------------------------------------------------------------------------
// rtpb_queue
// Two-entry queue of band words between the front and the back.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module rtpb_queue (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  rtpb_pkg::t_word_req i_push,
    output logic                o_push_ready,
    output rtpb_pkg::t_word_req o_head,
    input  logic                i_pop
);
    import rtpb_pkg::*;

    t_band_word        r_mem [QUEUE_DEPTH];
    logic [QPTR_W-1:0] r_wr_ptr;
    logic [QPTR_W-1:0] r_rd_ptr;
    logic [QCNT_W-1:0] r_count;

    logic push;
    logic pop;

    assign o_push_ready = (r_count < QCNT_W'(QUEUE_DEPTH));
    assign push         = i_push.valid && o_push_ready;
    assign o_head.valid = (r_count != '0);
    assign o_head.word  = r_mem[r_rd_ptr];
    assign pop          = i_pop && o_head.valid;

    // Store words
    always_ff @(posedge i_clk) begin
        if (push) begin
            r_mem[r_wr_ptr] <= i_push.word;
        end
    end

    // Advance pointers and count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (push) begin
                r_wr_ptr <= r_wr_ptr + 1'b1;
            end
            if (pop) begin
                r_rd_ptr <= r_rd_ptr + 1'b1;
            end
            unique case ({push, pop})
                2'b10:   r_count <= r_count + 1'b1;
                2'b01:   r_count <= r_count - 1'b1;
                default: r_count <= r_count;
            endcase
        end
    end

endmodule

`default_nettype wire

>>> rtl/rtpb_back.sv
// ---------------------------------------------------------------------------
// rtpb_back
// Turns each band word into eight column bytes, one per cycle while the output
// is not stalled, through an output register.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
`include "row_to_page_bitmap_transpose_assert.svh"

module rtpb_back (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  rtpb_pkg::t_word_req i_head,
    output logic                o_pop,
    rtpb_out_if.source          o_col
);
    import rtpb_pkg::*;

    localparam logic [2:0] LAST_BEAT = 3'(BEATS - 1);

    logic       r_busy;
    logic [2:0] r_beat;
    t_band_word r_word;
    logic       r_out_valid;
    logic [7:0] r_out_byte;
    logic       r_out_run;
    logic       r_out_frame;

    logic       load;
    logic       emit;
    logic       end_beat;
    logic [7:0] n_byte;

    assign load     = !r_out_valid || o_col.ready;
    assign emit     = load && r_busy;
    assign end_beat = (r_beat == LAST_BEAT);
    assign o_pop    = i_head.valid && (!r_busy || (emit && end_beat));

    // Gather one column: stored rows low, live row on top
    always_comb begin
        for (int r = 0; r < STORE_ROWS; r++) begin
            n_byte[r] = r_word.rows[r][r_beat];
        end
        n_byte[BAND_ROWS-1] = r_word.pixel[r_beat];
    end

    // Beat sequencing and word load
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy      <= 1'b0;
            r_beat      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (o_pop) begin
                r_busy <= 1'b1;
                r_beat <= '0;
            end else if (emit) begin
                r_beat <= r_beat + 1'b1;
                if (end_beat) begin
                    r_busy <= 1'b0;
                end
            end
            if (emit) begin
                r_out_valid <= 1'b1;
            end else if (load) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Payload registers
    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_word <= i_head.word;
        end
        if (emit) begin
            r_out_byte  <= n_byte;
            r_out_run   <= end_beat;
            r_out_frame <= end_beat && r_word.frame_last;
        end
    end

    assign o_col.valid       = r_out_valid;
    assign o_col.column_byte = r_out_byte;
    assign o_col.run_last    = r_out_run;
    assign o_col.frame_last  = r_out_frame;

    `RTPB_ASSERT_IMP(a_run_open, i_clk, i_rst_n, r_out_valid && !r_out_run, r_busy,
        "column byte shown mid-run without a word in work")
    `RTPB_ASSERT_IMP(a_frame_run, i_clk, i_rst_n, r_out_valid && r_out_frame, r_out_run,
        "frame mark off the end of a run")
    `RTPB_ASSERT_IMP(a_busy_src, i_clk, i_rst_n, $rose(r_busy), $past(i_head.valid),
        "work started without a queued word")

endmodule

`default_nettype wire

>>> rtl/row_to_page_bitmap_transpose.sv
// ---------------------------------------------------------------------------
// row_to_page_bitmap_transpose
// Row-packed monochrome bitmap in, page-packed column bytes out.
// ---------------------------------------------------------------------------
//  channel  dir  payload                                  word
//  i_cfg    in   index[3:0], data[7:0]                    register write
//  i_pix    in   pixel_byte[7:0]                          one row byte
//  o_col    out  column_byte[7:0], run_last, frame_last   one column byte
//
//  Rows 0..6 of a band: one byte per cycle, stored in the band store.
//  Row 7: each byte yields eight column bytes, one per cycle from the output
//  register while the output is not stalled.
//  Reset: synchronous; counters and queue clear at once, no clearing pass;
//  band-store contents are undefined until written.
//  Output stalls back up through the two-entry queue to row-7 input bytes.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module row_to_page_bitmap_transpose #(
    parameter int MAX_WIDTH_BYTES = rtpb_pkg::MAX_WIDTH_BYTES_DEF,
    parameter int MAX_PAGES       = rtpb_pkg::MAX_PAGES_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    rtpb_cfg_if.sink    i_cfg,
    rtpb_in_if.sink     i_pix,
    rtpb_out_if.source  o_col
);
    import rtpb_pkg::*;

    t_word_req push_req;
    t_word_req head;
    logic      push_ready;
    logic      pop;

    // Position tracking and band store
    rtpb_front #(
        .MAX_WIDTH_BYTES (MAX_WIDTH_BYTES),
        .MAX_PAGES       (MAX_PAGES)
    ) u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg        (i_cfg),
        .i_pix        (i_pix),
        .o_push       (push_req),
        .i_push_ready (push_ready)
    );

    // Decoupling queue
    rtpb_queue u_queue (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_push       (push_req),
        .o_push_ready (push_ready),
        .o_head       (head),
        .i_pop        (pop)
    );

    // Column byte emission
    rtpb_back u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_head  (head),
        .o_pop   (pop),
        .o_col   (o_col)
    );

endmodule

`default_nettype wire
